### sv/lptlb_pkg.sv
// shared types and widths for the lpt load balancer
// no dependencies; used by the cell modules and the top level
package lptlb_pkg;

	// fixed field widths of the result and job words
	localparam int TIME_W = 16;
	localparam int LOAD_W = 21;
	localparam int SET_W  = 32;
	localparam int PNUM_W = 5;
	localparam int JIDX_W = 5;
	localparam int PID_W  = 4;

	// saturation value of a processor load
	localparam logic [LOAD_W-1:0] LOAD_SAT = '1;

	// job word as it arrives
	typedef struct packed {
		logic [TIME_W-1:0] job_time;
		logic              final_job;
	} lptlb_in_t;

	// result word, one per processor
	typedef struct packed {
		logic [PNUM_W-1:0] processor_number;
		logic [LOAD_W-1:0] processor_load;
		logic [SET_W-1:0]  job_set;
		logic [LOAD_W-1:0] makespan;
		logic              jobs_dropped;
		logic              last_result;
	} lptlb_out_t;

	// one stored job in the sorting chain
	typedef struct packed {
		logic              vld;
		logic [TIME_W-1:0] t;
		logic [JIDX_W-1:0] idx;
	} job_ent_t;

	// what a job cell shows its neighbour below
	typedef struct packed {
		job_ent_t ent;
		logic     beats;
	} job_link_t;

	// one processor in the load chain
	typedef struct packed {
		logic              vld;
		logic [LOAD_W-1:0] load;
		logic [PID_W-1:0]  id;
		logic [SET_W-1:0]  jset;
	} proc_ent_t;

	// what a processor cell shows its neighbour above
	typedef struct packed {
		proc_ent_t ent;
		logic      lt;
	} proc_link_t;

endpackage

### sv/lptlb_job_cell.sv
// one cell of the job chain: keeps the jobs sorted longest first, ties by arrival
// depends on lptlb_pkg
module lptlb_job_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ins,
	input  logic                  pop,
	input  lptlb_pkg::job_ent_t   x,
	input  lptlb_pkg::job_link_t  prev,
	input  lptlb_pkg::job_ent_t   nxt,
	output lptlb_pkg::job_link_t  link
);
	import lptlb_pkg::*;

	logic              vld_q;
	logic [TIME_W-1:0] t_q;
	logic [JIDX_W-1:0] idx_q;
	job_ent_t          cur;
	job_ent_t          upd;
	logic              beats;

	// a later job only passes a strictly shorter one, so ties stay in arrival order
	assign cur   = '{vld: vld_q, t: t_q, idx: idx_q};
	assign beats = !vld_q || (x.t > t_q);
	assign link  = '{ent: cur, beats: beats};

	// shift up on pop, make room on insert
	always_comb begin
		upd = cur;
		if (pop) begin
			upd = nxt;
		end else if (ins && beats) begin
			upd = prev.beats ? prev.ent : x;
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= upd.vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		t_q   <= upd.t;
		idx_q <= upd.idx;
	end

endmodule

### sv/lptlb_proc_cell.sv
// one cell of the processor chain: kept in ascending order of load, ties by number
// depends on lptlb_pkg
module lptlb_proc_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   init,
	input  lptlb_pkg::proc_ent_t   init_ent,
	input  logic                   ins,
	input  logic                   pop,
	input  logic                   head_pos,
	input  lptlb_pkg::proc_ent_t   key,
	input  lptlb_pkg::proc_link_t  nxt,
	output lptlb_pkg::proc_link_t  link
);
	import lptlb_pkg::*;

	logic              vld_q;
	logic [LOAD_W-1:0] load_q;
	logic [PID_W-1:0]  id_q;
	logic [SET_W-1:0]  jset_q;
	proc_ent_t         cur;
	proc_ent_t         upd;
	logic              lt_me;

	// this cell orders before the updated head processor
	assign cur   = '{vld: vld_q, load: load_q, id: id_q, jset: jset_q};
	assign lt_me = vld_q && ((load_q < key.load) || ((load_q == key.load) && (id_q < key.id)));
	assign link  = '{ent: cur, lt: lt_me};

	// head leaves, the rest close up, the updated head drops into its slot
	always_comb begin
		upd = cur;
		if (init) begin
			upd = init_ent;
		end else if (pop) begin
			upd = nxt.ent;
		end else if (ins) begin
			if (nxt.lt) begin
				upd = nxt.ent;
			end else if (head_pos || lt_me) begin
				upd = key;
			end
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= upd.vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		load_q <= upd.load;
		id_q   <= upd.id;
		jset_q <= upd.jset;
	end

endmodule

### sv/lpt_load_balancer.sv
// top level of the lpt load balancer: job chain, processor chain, sequencer, result table
// depends on lptlb_pkg, lptlb_job_cell and lptlb_proc_cell
//
//   channel  | direction | handshake            | word
//   ---------+-----------+----------------------+---------------------------
//   job      | in        | job_valid/job_stall  | lptlb_in_t  (time, final)
//   res      | out       | res_valid/res_stall  | lptlb_out_t (one per proc)
//   cfg      | in        | cfg_wen              | cfg_wdata (processor count)
//
// jobs load one a cycle while job_stall is low and are sorted as they arrive by the job chain.
// after the final job, assignment passes one job a cycle through the processor
// chain, then comes the drain into the result table, and the results then leave
// one a cycle, P of them, unless res_stall holds them back.
// job_stall is high from the final job until the last result is in the output register.
// reset is asynchronous and clears control state only; no clearing pass.
module lpt_load_balancer #(
	parameter int MAX_JOBS  = 32,
	parameter int MAX_PROCS = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	output logic                   job_stall,
	input  lptlb_pkg::lptlb_in_t   job_word,
	output logic                   res_valid,
	input  logic                   res_stall,
	output lptlb_pkg::lptlb_out_t  res_word,
	input  logic                   cfg_wen,
	input  logic [4:0]             cfg_wdata
);
	import lptlb_pkg::*;

	localparam int PC    = (MAX_PROCS < 16) ? MAX_PROCS : 16;
	localparam int IDX_W = (PC > 1) ? $clog2(PC) : 1;
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int TB    = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
	localparam logic [TIME_W-1:0] TMASK = TIME_W'((33'd1 << TB) - 33'd1);

	typedef enum logic [3:0] {
		ST_LOAD   = 4'b0001,
		ST_ASSIGN = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	typedef struct packed {
		logic [LOAD_W-1:0] load;
		logic [SET_W-1:0]  jset;
	} res_ent_t;

	state_t            state_q;
	logic [4:0]        num_procs_q;
	logic [4:0]        p_q;
	logic [4:0]        p_act;
	logic [4:0]        e_q;
	logic [CNT_W-1:0]  job_cnt_q;
	logic              ovf_q;
	logic              res_valid_q;
	logic [LOAD_W-1:0] makespan_q;
	lptlb_out_t        res_q;
	res_ent_t          res_mem [PC];

	logic              job_acc;
	logic              job_ins;
	logic              job_pop;
	logic              proc_init;
	logic              proc_pop;
	logic              emit_go;
	logic              last_e;
	job_ent_t          job_in_ent;
	proc_ent_t         key;
	proc_ent_t         head;
	job_ent_t          job_head;
	logic [LOAD_W:0]   sum;

	job_link_t         job_lnk  [MAX_JOBS+2];
	proc_link_t        proc_lnk [PC+1];

	// handshake
	assign job_stall = (state_q != ST_LOAD);
	assign job_acc   = job_valid && !job_stall;
	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	// active processor count, zero counts as one, capped at the processor chain length
	always_comb begin
		p_act = num_procs_q;
		if (p_act == 5'd0) begin
			p_act = 5'd1;
		end
		if (p_act > 5'(PC)) begin
			p_act = 5'(PC);
		end
	end

	// strobes into the two chains
	assign job_ins    = job_acc && (job_cnt_q < CNT_W'(MAX_JOBS));
	assign job_in_ent = '{vld: 1'b1, t: job_word.job_time & TMASK, idx: JIDX_W'(job_cnt_q)};
	assign job_head   = job_lnk[1].ent;
	assign head       = proc_lnk[0].ent;
	assign job_pop    = (state_q == ST_ASSIGN) && job_head.vld;
	assign proc_init  = job_acc && job_word.final_job;
	assign proc_pop   = (state_q == ST_DRAIN) && head.vld;
	assign emit_go    = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);
	assign last_e     = (e_q == (p_q - 5'd1));

	// least loaded processor takes the longest remaining job, load saturates
	always_comb begin
		sum      = {1'b0, head.load} + {{(LOAD_W+1-TIME_W){1'b0}}, job_head.t};
		key.vld  = 1'b1;
		key.id   = head.id;
		key.load = sum[LOAD_W] ? LOAD_SAT : sum[LOAD_W-1:0];
		key.jset = head.jset | ({{(SET_W-1){1'b0}}, 1'b1} << job_head.idx);
	end

	// job chain, longest first
	assign job_lnk[0]          = '0;
	assign job_lnk[MAX_JOBS+1] = '0;
	for (genvar gi = 0; gi < MAX_JOBS; gi++) begin : g_job
		lptlb_job_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ins    (job_ins),
			.pop    (job_pop),
			.x      (job_in_ent),
			.prev   (job_lnk[gi]),
			.nxt    (job_lnk[gi+2].ent),
			.link   (job_lnk[gi+1])
		);
	end

	// processor chain, least loaded at the head
	assign proc_lnk[PC] = '0;
	for (genvar gi = 0; gi < PC; gi++) begin : g_proc
		proc_ent_t init_ent;
		assign init_ent = '{vld: (5'(gi) < p_act), load: '0, id: PID_W'(gi), jset: '0};
		lptlb_proc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.init     (proc_init),
			.init_ent (init_ent),
			.ins      (job_pop),
			.pop      (proc_pop),
			.head_pos (1'(gi == 0)),
			.key      (key),
			.nxt      (proc_lnk[gi+1]),
			.link     (proc_lnk[gi])
		);
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			num_procs_q <= 5'd1;
			p_q         <= 5'd1;
			e_q         <= 5'd0;
			job_cnt_q   <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				num_procs_q <= cfg_wdata;
			end
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (job_acc) begin
						if (job_ins) begin
							job_cnt_q <= job_cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (job_word.final_job) begin
							state_q <= ST_ASSIGN;
							p_q     <= p_act;
						end
					end
				end
				ST_ASSIGN: begin
					if (!job_head.vld) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!head.vld) begin
						state_q <= ST_EMIT;
						e_q     <= 5'd0;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						e_q <= e_q + 5'd1;
						if (last_e) begin
							state_q   <= ST_LOAD;
							job_cnt_q <= '0;
							ovf_q     <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result table by processor number, makespan from the last (largest) head
	always_ff @(posedge clk) begin
		if (proc_pop) begin
			res_mem[head.id[IDX_W-1:0]] <= '{load: head.load, jset: head.jset};
			makespan_q                  <= head.load;
		end
		if (emit_go) begin
			res_q.processor_number <= e_q + 5'd1;
			res_q.processor_load   <= res_mem[e_q[IDX_W-1:0]].load;
			res_q.job_set          <= res_mem[e_q[IDX_W-1:0]].jset;
			res_q.makespan         <= makespan_q;
			res_q.jobs_dropped     <= ovf_q;
			res_q.last_result      <= last_e;
		end
	end

	// no processor can carry more than the largest load
	a_makespan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.makespan >= res_word.processor_load))
		else $error("result load above makespan");

	// a final job opens the schedule with a live processor at the head
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job_stall && job_word.final_job) |=>
			((state_q == ST_ASSIGN) && proc_lnk[0].ent.vld))
		else $error("schedule did not start after final job");

	// every job has been placed before results go out
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !job_lnk[1].ent.vld)
		else $error("job left in chain during emission");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for lpt_load_balancer: job sets in, per-processor results checked
// depends on lptlb_pkg and lpt_load_balancer; holds its own scheduling predictor
module tb;
	import lptlb_pkg::*;

	localparam int STORE_DEPTH = 32;
	localparam int PROC_CAP    = 16;
	localparam int RX_HOLD     = 400;
	localparam int LIMIT       = 1000000;
	localparam int RAND_JOBS   = 300;

	// one pending job word with the idle cycles that come before it
	typedef struct {
		lptlb_in_t   w;
		int unsigned gap;
	} job_item_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        job_valid = 1'b0;
	logic        job_stall;
	lptlb_in_t   job_word  = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	lptlb_out_t  res_word;
	logic        cfg_wen   = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	// predictor state
	logic [TIME_W-1:0] job_store [STORE_DEPTH];
	int                job_count = 0;
	bit                store_over = 0;
	logic [4:0]        proc_cfg = 5'd1;

	job_item_t   job_q[$];
	lptlb_out_t  proc_results_q[$];

	int unsigned n_cycles = 0;
	int          n_errs = 0;
	int          n_jobs = 0;
	int          n_sets = 0;
	int          n_over_sets = 0;
	int          n_results = 0;
	int          n_queued = 0;
	int unsigned tx_cnt = 0;
	int unsigned rx_wait = 0;
	bit          rx_calm = 0;
	logic        hold_go = 1'b0;
	int unsigned hold_left = 0;

	lpt_load_balancer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_stall (job_stall),
		.job_word  (job_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// mismatch line, capped so a broken block does not flood the log
	task automatic report_diff(string what, longint got, longint want);
		n_errs++;
		if (n_errs <= 30)
			$display("tb: mismatch at result %0d: %s got %0d, want %0d",
				n_results, what, got, want);
	endtask

	// store one accepted job; a final job schedules the set longest first
	task automatic take_job(lptlb_in_t w);
		int                ord [STORE_DEPTH];
		logic [LOAD_W-1:0] ld [PROC_CAP];
		logic [SET_W-1:0]  js [PROC_CAP];
		logic [LOAD_W:0]   sum;
		logic [LOAD_W-1:0] span;
		lptlb_out_t        r;
		int                k, best, p, idx;
		n_jobs++;
		if (job_count < STORE_DEPTH) begin
			job_store[job_count] = w.job_time;
			job_count++;
		end else begin
			store_over = 1;
		end
		if (!w.final_job)
			return;
		p = (proc_cfg == 0) ? 1 : ((proc_cfg > PROC_CAP) ? PROC_CAP : int'(proc_cfg));
		// stable ordering by duration, longest first
		for (int i = 0; i < job_count; i++) begin
			k = i;
			while (k > 0 && job_store[ord[k-1]] < job_store[i]) begin
				ord[k] = ord[k-1];
				k--;
			end
			ord[k] = i;
		end
		for (int j = 0; j < PROC_CAP; j++) begin
			ld[j] = '0;
			js[j] = '0;
		end
		// each job to the least loaded processor, lowest number on a tie
		for (int i = 0; i < job_count; i++) begin
			idx = ord[i];
			best = 0;
			for (int j = 1; j < p; j++)
				if (ld[j] < ld[best])
					best = j;
			sum = {1'b0, ld[best]} + job_store[idx];
			ld[best] = sum[LOAD_W] ? LOAD_SAT : sum[LOAD_W-1:0];
			js[best][idx] = 1'b1;
		end
		span = '0;
		for (int j = 0; j < p; j++)
			if (ld[j] > span)
				span = ld[j];
		for (int j = 0; j < p; j++) begin
			r.processor_number = PNUM_W'(j + 1);
			r.processor_load   = ld[j];
			r.job_set          = js[j];
			r.makespan         = span;
			r.jobs_dropped     = store_over;
			r.last_result      = (j == p - 1);
			proc_results_q = {proc_results_q, r};
		end
		n_sets++;
		if (store_over)
			n_over_sets++;
		job_count = 0;
		store_over = 0;
	endtask

	// job driver: offers queued words after their idle gap
	always @(posedge clk) begin
		if (!arst_n) begin
			job_valid <= 1'b0;
			tx_cnt = 0;
		end else begin
			if (job_valid && !job_stall)
				take_job(job_word);
			if (!job_valid || !job_stall) begin
				if (job_q.size() != 0 && tx_cnt >= job_q[0].gap) begin
					job_word  <= job_q[0].w;
					job_valid <= 1'b1;
					void'(job_q.pop_front());
					tx_cnt = 0;
				end else begin
					job_valid <= 1'b0;
					if (job_q.size() != 0)
						tx_cnt++;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_go)
			hold_left <= RX_HOLD;
	end

	// result receiver: random stall after each word, with calm stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if ($urandom_range(0, 15) == 0)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
			end
			if (hold_left > 1) begin
				res_stall <= 1'b1;
			end else if (rx_wait != 0) begin
				rx_wait--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// result monitor: each word against the oldest expected one
	always @(posedge clk) begin
		lptlb_out_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (proc_results_q.size() == 0) begin
				report_diff("unexpected word, processor_number", res_word.processor_number, 0);
			end else begin
				want = proc_results_q.pop_front();
				if (res_word.processor_number !== want.processor_number)
					report_diff("processor_number", res_word.processor_number,
						want.processor_number);
				if (res_word.processor_load !== want.processor_load)
					report_diff("processor_load", res_word.processor_load,
						want.processor_load);
				if (res_word.job_set !== want.job_set)
					report_diff("job_set", res_word.job_set, want.job_set);
				if (res_word.makespan !== want.makespan)
					report_diff("makespan", res_word.makespan, want.makespan);
				if (res_word.jobs_dropped !== want.jobs_dropped)
					report_diff("jobs_dropped", res_word.jobs_dropped, want.jobs_dropped);
				if (res_word.last_result !== want.last_result)
					report_diff("last_result", res_word.last_result, want.last_result);
			end
			n_results++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d words still expected",
				n_cycles, proc_results_q.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	// wait until every job is taken and every result is back, then let the block go quiet
	task automatic settle();
		while (job_q.size() != 0 || job_valid || proc_results_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_procs(logic [4:0] v);
		settle();
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		proc_cfg = v;
	endtask

	task automatic add_job(logic [TIME_W-1:0] t, bit fin, bit quiet);
		job_item_t it;
		it.w.job_time  = t;
		it.w.final_job = fin;
		it.gap = quiet ? 0 : $urandom_range(0, 18);
		job_q = {job_q, it};
		n_queued++;
	endtask

	// one random job set; the duration style is drawn per set
	task automatic add_set(int n, bit quiet);
		int                style;
		logic [TIME_W-1:0] t;
		style = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			case (style)
				0: begin
					t = TIME_W'($urandom_range(0, 3));
				end
				1: begin
					case ($urandom_range(0, 2))
						0: t = '0;
						1: t = '1;
						default: t = TIME_W'($urandom_range(0, 65535));
					endcase
				end
				default: begin
					t = TIME_W'($urandom_range(0, 65535));
				end
			endcase
			add_job(t, i == n - 1, quiet);
		end
	endtask

	// stimulus and end of run
	initial begin
		int          ph;
		int          size;
		int          nsets;
		logic [4:0]  v;
		bit          quiet;
		logic [4:0]  first_cfgs [5];
		first_cfgs = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// single jobs at the duration extremes
		write_procs(5'd1);
		add_job(16'hFFFF, 1, 0);
		add_job(16'h0000, 1, 0);
		// more processors than jobs, count clamped to the maximum
		write_procs(5'd31);
		add_job(16'd5, 0, 0);
		add_job(16'hFFFF, 0, 0);
		add_job(16'd5, 1, 0);
		// zero count taken as one processor
		write_procs(5'd0);
		add_job(16'd7, 0, 0);
		add_job(16'd7, 0, 0);
		add_job(16'd0, 1, 0);
		// equal durations and equal loads
		write_procs(5'd3);
		add_job(16'd10, 0, 0);
		add_job(16'd20, 0, 0);
		add_job(16'd10, 0, 0);
		add_job(16'd20, 0, 0);
		add_job(16'd30, 0, 0);
		add_job(16'd10, 1, 0);
		for (int i = 0; i < 4; i++)
			add_job(16'hFFFF, i == 3, 1);

		// random phases, each under its own processor count
		ph = 0;
		while (n_queued < RAND_JOBS) begin
			v = (ph < 5) ? first_cfgs[ph] : 5'($urandom_range(0, 31));
			write_procs(v);
			if (ph == 1) begin
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			nsets = $urandom_range(2, 4);
			for (int s = 0; s < nsets && n_queued < RAND_JOBS; s++) begin
				quiet = (ph == 1) || ($urandom_range(0, 3) == 0);
				if (ph == 0 && s == 0) begin
					size = 33;
				end else if (ph == 2 && s == 0) begin
					size = 40;
				end else begin
					case ($urandom_range(0, 9))
						0: size = $urandom_range(33, 40);
						1: size = 32;
						default: size = $urandom_range(1, 20);
					endcase
				end
				add_set(size, quiet);
			end
			ph++;
		end

		settle();
		$display("tb: %0d jobs in %0d sets, %0d processor words compared",
			n_jobs, n_sets, n_results);
		$display("tb: %0d sets overran the job store, %0d processor count phases",
			n_over_sets, ph + 4);
		if (n_errs == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

### sim.f
sv/lptlb_pkg.sv
sv/lptlb_job_cell.sv
sv/lptlb_proc_cell.sv
sv/lpt_load_balancer.sv
test/tb.sv
